@@ hdl/stma_pkg.sv @@
// Shared types and constants for the sparse triplet merge-add core.
package stma_pkg;

	localparam int TOTAL_W = 6;
	localparam int MODE_W  = 2;

	localparam logic [MODE_W-1:0] MODE_LOAD_A = 2'd0;
	localparam logic [MODE_W-1:0] MODE_LOAD_B = 2'd1;
	localparam logic [MODE_W-1:0] MODE_RUN    = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_COUNT,
		ST_EMIT
	} state_t;

endpackage

@@ hdl/sparse_triplet_merge_add_core.sv @@
// Sparse matrix addition by merging two triplet lists, with saturating sums.
// Load transfers leave the block ready again in the next cycle.
// A run takes a counting pass over both lists (one merge step per cycle,
// then a step to see the end), then an emit pass with one step per cycle,
// held while the output register is stalled, and a final step to finish.
// Reset (arst_n low) empties both lists and clears the overflow flag.
module sparse_triplet_merge_add_core
	import stma_pkg::*;
#(
	parameter int DEPTH      = 16,
	parameter int COORD_BITS = 8,
	parameter int VALUE_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// row, col, value, zero fill
	input  logic [(((2*COORD_BITS+VALUE_BITS)+7)/8)*8-1:0] s_tdata,
	// mode
	input  logic [MODE_W-1:0] s_tuser,
	output logic m_tvalid,
	input  logic m_tready,
	// out_row, out_col, out_value, overflow, total, zero fill
	output logic [(((2*COORD_BITS+VALUE_BITS+1+TOTAL_W)+7)/8)*8-1:0] m_tdata,
	// valid_res
	output logic m_tuser,
	output logic m_tlast
);

	localparam int EW     = 2*COORD_BITS + VALUE_BITS;
	localparam int IW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW     = $clog2(DEPTH + 1);
	localparam int NW     = $clog2(2*DEPTH + 1);
	localparam int OUT_P  = EW + 1 + TOTAL_W;
	localparam int OUT_W  = ((OUT_P + 7) / 8) * 8;

	state_t state_q, state_d;

	logic [EW-1:0] a_mem_q [DEPTH];
	logic [EW-1:0] b_mem_q [DEPTH];
	logic [CW-1:0] a_cnt_q, b_cnt_q, i_q, j_q;
	logic [NW-1:0] n_q, k_q;
	logic          ov_q;

	logic                  out_vld_q, out_res_q, out_last_q, out_ov_q;
	logic [COORD_BITS-1:0] out_row_q, out_col_q;
	logic [VALUE_BITS-1:0] out_val_q;
	logic [TOTAL_W-1:0]    out_tot_q;

	// merge step unit
	logic [EW-1:0]         a_e, b_e;
	logic [COORD_BITS-1:0] a_row, a_col, b_row, b_col;
	logic [VALUE_BITS-1:0] a_val, b_val;
	logic signed [VALUE_BITS:0] sum;
	logic                  a_ok, b_ok, st_done, st_a, st_b, st_emit, st_sat;
	logic [COORD_BITS-1:0] st_row, st_col;
	logic [VALUE_BITS-1:0] st_val, sat_val;

	logic in_fire, slot_free, ld_item;

	assign a_e   = a_mem_q[i_q[IW-1:0]];
	assign b_e   = b_mem_q[j_q[IW-1:0]];
	assign a_row = a_e[COORD_BITS-1:0];
	assign a_col = a_e[2*COORD_BITS-1:COORD_BITS];
	assign a_val = a_e[EW-1:2*COORD_BITS];
	assign b_row = b_e[COORD_BITS-1:0];
	assign b_col = b_e[2*COORD_BITS-1:COORD_BITS];
	assign b_val = b_e[EW-1:2*COORD_BITS];
	assign a_ok  = (i_q < a_cnt_q);
	assign b_ok  = (j_q < b_cnt_q);
	assign sum   = $signed({a_val[VALUE_BITS-1], a_val}) + $signed({b_val[VALUE_BITS-1], b_val});
	assign sat_val = sum[VALUE_BITS] ? {1'b1, {(VALUE_BITS-1){1'b0}}}
	                                 : {1'b0, {(VALUE_BITS-1){1'b1}}};

	always_comb begin
		st_done = 1'b0;
		st_a    = 1'b0;
		st_b    = 1'b0;
		st_emit = 1'b1;
		st_sat  = 1'b0;
		st_row  = a_row;
		st_col  = a_col;
		st_val  = a_val;
		if (a_ok && b_ok) begin
			if ({a_row, a_col} == {b_row, b_col}) begin
				st_a   = 1'b1;
				st_b   = 1'b1;
				st_sat = sum[VALUE_BITS] ^ sum[VALUE_BITS-1];
				st_val = st_sat ? sat_val : sum[VALUE_BITS-1:0];
				st_emit = (sum != '0);
			end else if ({a_row, a_col} < {b_row, b_col}) begin
				st_a = 1'b1;
			end else begin
				st_b   = 1'b1;
				st_row = b_row;
				st_col = b_col;
				st_val = b_val;
			end
		end else if (a_ok) begin
			st_a = 1'b1;
		end else if (b_ok) begin
			st_b   = 1'b1;
			st_row = b_row;
			st_col = b_col;
			st_val = b_val;
		end else begin
			st_done = 1'b1;
			st_emit = 1'b0;
		end
	end

	assign in_fire   = s_tvalid && s_tready;
	assign slot_free = !out_vld_q || m_tready;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_fire && s_tuser == MODE_RUN) state_d = ST_COUNT;
			end
			ST_COUNT: begin
				if (st_done) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (slot_free && (st_done || n_q == '0)) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		s_tready = (state_q == ST_IDLE);
		ld_item  = (state_q == ST_EMIT) && slot_free && ((st_emit && !st_done) || n_q == '0);
		m_tvalid = out_vld_q;
		m_tuser  = out_res_q;
		m_tlast  = out_last_q;
		m_tdata  = OUT_W'({out_tot_q, out_ov_q, out_val_q, out_col_q, out_row_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			a_cnt_q   <= '0;
			b_cnt_q   <= '0;
			i_q       <= '0;
			j_q       <= '0;
			n_q       <= '0;
			k_q       <= '0;
			ov_q      <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ld_item) out_vld_q <= 1'b1;
			else if (m_tready) out_vld_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						if (s_tuser == MODE_LOAD_A) begin
							if (a_cnt_q < CW'(DEPTH)) a_cnt_q <= a_cnt_q + 1'b1;
							else ov_q <= 1'b1;
						end else if (s_tuser == MODE_LOAD_B) begin
							if (b_cnt_q < CW'(DEPTH)) b_cnt_q <= b_cnt_q + 1'b1;
							else ov_q <= 1'b1;
						end
					end
					i_q <= '0;
					j_q <= '0;
					n_q <= '0;
					k_q <= '0;
				end
				ST_COUNT: begin
					if (st_done) begin
						i_q <= '0;
						j_q <= '0;
					end else begin
						if (st_a) i_q <= i_q + 1'b1;
						if (st_b) j_q <= j_q + 1'b1;
						if (st_emit) n_q <= n_q + 1'b1;
						if (st_sat) ov_q <= 1'b1;
					end
				end
				ST_EMIT: begin
					if (slot_free) begin
						if (st_done || n_q == '0) begin
							a_cnt_q <= '0;
							b_cnt_q <= '0;
							ov_q    <= 1'b0;
						end else begin
							if (st_a) i_q <= i_q + 1'b1;
							if (st_b) j_q <= j_q + 1'b1;
							if (st_emit) k_q <= k_q + 1'b1;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// list storage
	always_ff @(posedge clk) begin
		if (in_fire && s_tuser == MODE_LOAD_A && a_cnt_q < CW'(DEPTH))
			a_mem_q[a_cnt_q[IW-1:0]] <= s_tdata[EW-1:0];
		if (in_fire && s_tuser == MODE_LOAD_B && b_cnt_q < CW'(DEPTH))
			b_mem_q[b_cnt_q[IW-1:0]] <= s_tdata[EW-1:0];
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (ld_item) begin
			out_ov_q <= ov_q;
			if (n_q == '0) begin
				out_res_q  <= 1'b0;
				out_last_q <= 1'b1;
				out_row_q  <= '0;
				out_col_q  <= '0;
				out_val_q  <= '0;
				out_tot_q  <= '0;
			end else begin
				out_res_q  <= 1'b1;
				out_row_q  <= st_row;
				out_col_q  <= st_col;
				out_val_q  <= st_val;
				out_last_q <= ((k_q + 1'b1) == n_q);
				out_tot_q  <= ((k_q + 1'b1) == n_q) ? TOTAL_W'(n_q) : '0;
			end
		end
	end

endmodule

@@ tb/sv/sparse_triplet_merge_add_core_test.sv @@
// Self-checking stream testbench for the sparse triplet merge-add core.
`timescale 1ns / 1ps

module sparse_triplet_merge_add_core_test;
	import stma_pkg::*;

	localparam int IN_W       = 32;
	localparam int OUT_W      = 40;
	localparam int LIST_DEPTH = 16;
	localparam int VAL_MAX    = 32767;
	localparam int VAL_MIN    = -32768;
	localparam int IDLE_PCT   = 12;
	localparam int HOLD_CYC   = 300;
	localparam int DRAIN_CYC  = 40;
	localparam int STALL_LIMIT = 3000;
	localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

	typedef struct {
		logic [MODE_W-1:0] mode;
		logic [7:0] row;
		logic [7:0] col;
		logic signed [15:0] value;
	} cmd_t;

	typedef struct {
		logic [7:0] row;
		logic [7:0] col;
		logic signed [15:0] value;
	} entry_t;

	typedef struct {
		logic [7:0] row;
		logic [7:0] col;
		logic [15:0] value;
		logic valid_res;
		logic last;
		logic overflow;
		logic [TOTAL_W-1:0] total;
	} sum_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	// row, col, value
	logic [IN_W-1:0] s_tdata = '0;
	// mode
	logic [MODE_W-1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	// out_row, out_col, out_value, overflow, total, zero fill
	logic [OUT_W-1:0] m_tdata;
	// valid_res
	logic m_tuser;
	logic m_tlast;

	cmd_t cmds_pending[$];
	sum_t sums_due[$];
	entry_t list_a[$];
	entry_t list_b[$];
	logic dropped_or_sat = 1'b0;
	cmd_t cur_cmd;
	int fail_cnt = 0;
	int cyc = 0;
	int results_seen = 0;
	int hold_left = 0;
	logic held_once = 1'b0;
	int stall_cyc = 0;
	logic quiet;

	sparse_triplet_merge_add_core u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// long stretch with no idling on either side
	assign quiet = (cyc >= 300) && (cyc < 800);

	// applies one accepted command; a run pushes the merged triplets it yields
	function automatic void merge_add(cmd_t c);
		entry_t e;
		sum_t r;
		sum_t merged[$];
		int i;
		int j;
		int s;
		logic [15:0] ka;
		logic [15:0] kb;
		e.row = c.row;
		e.col = c.col;
		e.value = c.value;
		if (c.mode == MODE_LOAD_A) begin
			if (list_a.size() < LIST_DEPTH)
				list_a.push_back(e);
			else
				dropped_or_sat = 1'b1;
			return;
		end
		if (c.mode == MODE_LOAD_B) begin
			if (list_b.size() < LIST_DEPTH)
				list_b.push_back(e);
			else
				dropped_or_sat = 1'b1;
			return;
		end
		if (c.mode != MODE_RUN)
			return;
		i = 0;
		j = 0;
		r = '{default: '0};
		r.valid_res = 1'b1;
		while (i < list_a.size() || j < list_b.size()) begin
			ka = {list_a[i].row, list_a[i].col};
			kb = {list_b[j].row, list_b[j].col};
			if (i < list_a.size() && j < list_b.size() && ka == kb) begin
				s = list_a[i].value + list_b[j].value;
				if (s > VAL_MAX) begin
					s = VAL_MAX;
					dropped_or_sat = 1'b1;
				end
				if (s < VAL_MIN) begin
					s = VAL_MIN;
					dropped_or_sat = 1'b1;
				end
				if (s != 0) begin
					r.row = list_a[i].row;
					r.col = list_a[i].col;
					r.value = 16'(s);
					merged.push_back(r);
				end
				i++;
				j++;
			end else if (j >= list_b.size() || (i < list_a.size() && ka < kb)) begin
				r.row = list_a[i].row;
				r.col = list_a[i].col;
				r.value = list_a[i].value;
				merged.push_back(r);
				i++;
			end else begin
				r.row = list_b[j].row;
				r.col = list_b[j].col;
				r.value = list_b[j].value;
				merged.push_back(r);
				j++;
			end
		end
		if (merged.size() == 0) begin
			r = '{default: '0};
			r.last = 1'b1;
			merged.push_back(r);
		end else begin
			merged[merged.size()-1].last = 1'b1;
			merged[merged.size()-1].total = TOTAL_W'(merged.size());
		end
		foreach (merged[k]) begin
			merged[k].overflow = dropped_or_sat;
			sums_due.push_back(merged[k]);
		end
		list_a.delete();
		list_b.delete();
		dropped_or_sat = 1'b0;
	endfunction

	function automatic void check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %0h, got %0h", name, exp_v, act_v);
			fail_cnt++;
		end
	endfunction

	task automatic push_cmd(logic [MODE_W-1:0] mode, int row, int col, int value);
		cmd_t c;
		c.mode = mode;
		c.row = 8'(row);
		c.col = 8'(col);
		c.value = 16'(value);
		cmds_pending.push_back(c);
	endtask

	function automatic int rand_value();
		int p;
		p = $urandom_range(0, 99);
		if (p < 5)
			return 0;
		if (p < 10)
			return VAL_MAX;
		if (p < 15)
			return VAL_MIN;
		return int'(16'($urandom)) - 32768;
	endfunction

	// one batch of loads into the lists, at times with a spare-mode command, followed by a run
	task automatic gen_batch();
		cmd_t qa[$];
		cmd_t qb[$];
		cmd_t c;
		int key;
		int nkeys;
		int pick;
		int va;
		int vb;
		int extra;
		int k;
		key = $urandom_range(0, 55000);
		nkeys = $urandom_range(0, 12);
		if ($urandom_range(0, 99) < 6) begin
			// unsorted loads over a tiny key space
			for (k = 0; k < nkeys; k++) begin
				c.row = 8'($urandom_range(0, 3));
				c.col = 8'($urandom_range(0, 3));
				c.value = 16'(rand_value());
				c.mode = $urandom_range(0, 1) ? MODE_LOAD_B : MODE_LOAD_A;
				if (c.mode == MODE_LOAD_A)
					qa.push_back(c);
				else
					qb.push_back(c);
			end
		end else begin
			for (k = 0; k < nkeys; k++) begin
				key += ($urandom_range(0, 3) == 0) ? $urandom_range(200, 300) :
					$urandom_range(1, 3);
				c.row = 8'(key >> 8);
				c.col = 8'(key);
				pick = $urandom_range(0, 2);
				va = rand_value();
				vb = rand_value();
				if (pick == 2) begin
					case ($urandom_range(0, 4))
						0: vb = -va;
						1: begin
							va = $urandom_range(20000, 32767);
							vb = $urandom_range(20000, 32767);
						end
						2: begin
							va = -int'($urandom_range(20000, 32768));
							vb = -int'($urandom_range(20000, 32768));
						end
						default: ;
					endcase
				end
				if (pick != 1) begin
					c.mode = MODE_LOAD_A;
					c.value = 16'(va);
					qa.push_back(c);
				end
				if (pick != 0) begin
					c.mode = MODE_LOAD_B;
					c.value = 16'(vb);
					qb.push_back(c);
				end
			end
		end
		if ($urandom_range(0, 99) < 10) begin
			// push one list past its depth
			pick = $urandom_range(0, 1);
			extra = LIST_DEPTH + 1 - (pick ? qb.size() : qa.size()) + $urandom_range(0, 2);
			repeat (extra) begin
				key += $urandom_range(1, 3);
				c.row = 8'(key >> 8);
				c.col = 8'(key);
				c.value = 16'(rand_value());
				c.mode = pick ? MODE_LOAD_B : MODE_LOAD_A;
				if (pick)
					qb.push_back(c);
				else
					qa.push_back(c);
			end
		end
		if ($urandom_range(0, 9) == 0)
			push_cmd(MODE_SPARE, $urandom, $urandom, $urandom);
		while (qa.size() > 0 || qb.size() > 0) begin
			if (qb.size() == 0 || (qa.size() > 0 && $urandom_range(0, 1)))
				cmds_pending.push_back(qa.pop_front());
			else
				cmds_pending.push_back(qb.pop_front());
		end
		push_cmd(MODE_RUN, $urandom, $urandom, $urandom);
	endtask

	always @(posedge clk)
		cyc <= cyc + 1;

	// sender
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || s_tready) begin
			if (s_tvalid)
				merge_add(cur_cmd);
			if (cmds_pending.size() > 0 && (quiet || $urandom_range(0, 99) >= IDLE_PCT)) begin
				cur_cmd = cmds_pending.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= {cur_cmd.value, cur_cmd.col, cur_cmd.row};
				s_tuser <= cur_cmd.mode;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// receiver, with one long hold-off once results are flowing
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else if (!held_once && results_seen >= 40) begin
			held_once <= 1'b1;
			hold_left <= HOLD_CYC;
			m_tready <= 1'b0;
		end else begin
			m_tready <= quiet || $urandom_range(0, 99) >= IDLE_PCT;
		end
	end

	// result checker
	always @(posedge clk) begin
		sum_t r;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen <= results_seen + 1;
			if (sums_due.size() == 0) begin
				$error("unexpected result transfer: %0h", m_tdata);
				fail_cnt++;
			end else begin
				r = sums_due.pop_front();
				check_field("out_row", r.row, m_tdata[7:0]);
				check_field("out_col", r.col, m_tdata[15:8]);
				check_field("out_value", r.value, m_tdata[31:16]);
				check_field("valid_res", r.valid_res, m_tuser);
				check_field("last", r.last, m_tlast);
				check_field("overflow", r.overflow, m_tdata[32]);
				check_field("total", r.total, m_tdata[33 +: TOTAL_W]);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				stall_cyc <= 0;
			else
				stall_cyc <= stall_cyc + 1;
			if (stall_cyc >= STALL_LIMIT) begin
				$display("sparse_triplet_merge_add_core_test: errors");
				$finish;
			end
		end
	end

	initial begin
		// empty lists give one empty item
		push_cmd(MODE_RUN, 0, 0, 0);
		// saturation at both ends
		push_cmd(MODE_LOAD_A, 0, 0, VAL_MAX);
		push_cmd(MODE_LOAD_B, 0, 0, 1);
		push_cmd(MODE_LOAD_A, 255, 255, VAL_MIN);
		push_cmd(MODE_LOAD_B, 255, 255, -1);
		push_cmd(MODE_RUN, 255, 255, -1);
		// cancelling pair, zero value, B-only entry, spare mode ignored
		push_cmd(MODE_LOAD_A, 1, 2, 5);
		push_cmd(MODE_LOAD_B, 1, 2, -5);
		push_cmd(MODE_LOAD_A, 3, 4, 0);
		push_cmd(MODE_LOAD_B, 2, 0, -7);
		push_cmd(MODE_SPARE, 255, 255, -1);
		push_cmd(MODE_RUN, 0, 0, 0);
		// everything cancels: empty result
		push_cmd(MODE_LOAD_A, 9, 9, 100);
		push_cmd(MODE_LOAD_B, 9, 9, -100);
		push_cmd(MODE_RUN, 0, 0, 0);
		// out-of-order loads
		push_cmd(MODE_LOAD_A, 5, 1, 1);
		push_cmd(MODE_LOAD_A, 4, 0, 2);
		push_cmd(MODE_LOAD_B, 4, 9, 3);
		push_cmd(MODE_RUN, 0, 0, 0);
		while (cmds_pending.size() < 225)
			gen_batch();

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		while (cmds_pending.size() > 0 || s_tvalid || sums_due.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);
		if (fail_cnt == 0 && sums_due.size() == 0)
			$display("sparse_triplet_merge_add_core_test: clean");
		else
			$display("sparse_triplet_merge_add_core_test: errors");
		$finish;
	end

endmodule

@@ filelist.f @@
hdl/stma_pkg.sv
hdl/sparse_triplet_merge_add_core.sv
tb/sv/sparse_triplet_merge_add_core_test.sv
